FILE: design/dsps_pkg.sv
// Package with shared constants, coil tables and the result word type.
package dsps_pkg;

  // Position counts for the two motors.
  localparam int CURTAIN_POSITIONS   = 8;
  localparam int STRETCHER_POSITIONS = 4;

  // Field widths.
  localparam int SPP_W   = 10;
  localparam int CPOS_W  = 3;
  localparam int SPOS_W  = 2;
  localparam int STEPS_W = CPOS_W + SPP_W;

  // Reset values of the steps-per-position registers.
  localparam logic [SPP_W-1:0] CURTAIN_SPP_RESET   = 10'd200;
  localparam logic [SPP_W-1:0] STRETCHER_SPP_RESET = 10'd50;

  // Input kinds carried on tuser.
  localparam logic KIND_TICK    = 1'b0;
  localparam logic KIND_COMMAND = 1'b1;

  // Motor codes.
  localparam logic MOTOR_STRETCHER = 1'b0;
  localparam logic MOTOR_CURTAIN   = 1'b1;

  // Configuration register indexes.
  localparam logic REG_CURTAIN_SPP   = 1'b0;
  localparam logic REG_STRETCHER_SPP = 1'b1;

  // Result word, highest field first when packed into tdata.
  typedef struct packed {
    logic [SPOS_W-1:0] stretcher_position_out;
    logic [CPOS_W-1:0] curtain_position_out;
    logic              command_accepted;
    logic              move_indicator;
    logic              busy_res;
    logic [7:0]        coil_pattern;
  } result_t;

  // Coil nibble for one phase of a full step in either direction.
  function automatic logic [3:0] coil_nibble(input logic forward, input logic [1:0] phase);
    logic [3:0] nib;
    nib = 4'b1001;
    case (phase)
      2'd0: nib = forward ? 4'b0011 : 4'b1100;
      2'd1: nib = 4'b0110;
      2'd2: nib = forward ? 4'b1100 : 4'b0011;
      2'd3: nib = 4'b1001;
      default: nib = 4'b1001;
    endcase
    return nib;
  endfunction

endpackage

FILE: design/dual_stepper_position_sequencer.sv
// Top level: two-motor stepper position sequencer with a two-entry output buffer.
//
//  Channel  | Direction | Payload
//  s_*      | in        | tuser: kind; tdata: motor_select, target_position
//  m_*      | out       | tdata: coil_pattern, busy_res, move_indicator,
//           |           |        command_accepted, curtain/stretcher position
//  cfg_*    | in        | index 0 curtain, 1 stretcher steps per position
//
// Every input word yields one result word; a word can be accepted in every
// cycle while the skid entry is empty. State updates and the result are formed
// in a single pass of logic and land in the output register, with one skid
// entry behind it. s_tready drops only while the skid entry is full, i.e. after
// a stalled output. Reset (rst, synchronous) clears positions, the move state
// and the buffer, and loads the steps-per-position registers with 200 and 50.
module dual_stepper_position_sequencer
  import dsps_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // [0] motor_select, [8:1] target_position, rest zero
  input  logic              s_tuser,   // [0] kind
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // [7:0] coil_pattern, [8] busy_res, [9] move_indicator,
                                       // [10] command_accepted, [13:11] curtain_position_out,
                                       // [15:14] stretcher_position_out
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SPP_W-1:0]  cfg_data
);

  // Configuration registers.
  logic [SPP_W-1:0] curtain_spp;
  logic [SPP_W-1:0] stretcher_spp;

  // Move state.
  logic [CPOS_W-1:0]  curtain_position, curtain_position_next;
  logic [SPOS_W-1:0]  stretcher_position, stretcher_position_next;
  logic [CPOS_W-1:0]  pending_target, pending_target_next;
  logic               active_motor, active_motor_next;
  logic               move_forward, move_forward_next;
  logic [1:0]         phase_index, phase_index_next;
  logic [STEPS_W-1:0] steps_left, steps_left_next;
  logic               moving, moving_next;

  // Output buffer.
  result_t out_word, skid_word, result;
  logic    out_valid, skid_valid;

  logic              in_acc;
  logic              kind;
  logic              motor_select;
  logic [7:0]        target_position;
  logic [CPOS_W-1:0] cur_pos;
  logic [SPP_W-1:0]  spp;
  logic [CPOS_W-1:0] span;
  logic [STEPS_W-1:0] move_steps;
  logic              target_ok;
  logic [3:0]        nib;
  logic [7:0]        pattern;
  logic              accepted;
  logic [STEPS_W-1:0] steps_dec;

  assign in_acc          = s_tvalid && s_tready;
  assign kind            = s_tuser;
  assign motor_select    = s_tdata[0];
  assign target_position = s_tdata[8:1];
  assign s_tready        = !skid_valid;
  assign m_tvalid        = out_valid;
  assign m_tdata         = out_word;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      curtain_spp   <= CURTAIN_SPP_RESET;
      stretcher_spp <= STRETCHER_SPP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURTAIN_SPP:   curtain_spp   <= cfg_data;
        REG_STRETCHER_SPP: stretcher_spp <= cfg_data;
        default: ;
      endcase
    end
  end

  // Command decode: range check, distance and step count of the move.
  always_comb begin
    if (motor_select == MOTOR_CURTAIN) begin
      target_ok = target_position < 8'(CURTAIN_POSITIONS);
      cur_pos   = curtain_position;
      spp       = curtain_spp;
    end else begin
      target_ok = target_position < 8'(STRETCHER_POSITIONS);
      cur_pos   = CPOS_W'(stretcher_position);
      spp       = stretcher_spp;
    end
    if (target_position[CPOS_W-1:0] > cur_pos) begin
      span = target_position[CPOS_W-1:0] - cur_pos;
    end else begin
      span = cur_pos - target_position[CPOS_W-1:0];
    end
    move_steps = STEPS_W'(span) * STEPS_W'(spp);
  end

  // Coil pattern of the current phase.
  assign nib       = coil_nibble(move_forward, phase_index);
  assign steps_dec = (steps_left != '0) ? steps_left - STEPS_W'(1) : steps_left;

  // Next state for one input word.
  always_comb begin
    curtain_position_next   = curtain_position;
    stretcher_position_next = stretcher_position;
    pending_target_next     = pending_target;
    active_motor_next       = active_motor;
    move_forward_next       = move_forward;
    phase_index_next        = phase_index;
    steps_left_next         = steps_left;
    moving_next             = moving;
    pattern                 = 8'h00;
    accepted                = 1'b0;
    if (kind == KIND_TICK) begin
      if (moving) begin
        pattern          = (active_motor == MOTOR_CURTAIN) ? {4'h0, nib} : {nib, 4'h0};
        phase_index_next = phase_index + 2'd1;
        if (phase_index == 2'd3) begin
          steps_left_next = steps_dec;
          // Last full step done: commit the position.
          if (steps_dec == '0) begin
            if (active_motor == MOTOR_CURTAIN) begin
              curtain_position_next = pending_target;
            end else begin
              stretcher_position_next = pending_target[SPOS_W-1:0];
            end
            moving_next = 1'b0;
          end
        end
      end
    end else if (!moving && target_ok) begin
      accepted            = 1'b1;
      active_motor_next   = motor_select;
      pending_target_next = target_position[CPOS_W-1:0];
      move_forward_next   = target_position[CPOS_W-1:0] > cur_pos;
      phase_index_next    = 2'd0;
      steps_left_next     = move_steps;
      moving_next         = 1'b1;
      // Zero-length move completes at once.
      if (move_steps == '0) begin
        if (motor_select == MOTOR_CURTAIN) begin
          curtain_position_next = target_position[CPOS_W-1:0];
        end else begin
          stretcher_position_next = target_position[SPOS_W-1:0];
        end
        moving_next = 1'b0;
      end
    end
    result.coil_pattern           = pattern;
    result.busy_res               = moving_next;
    result.move_indicator         = moving_next;
    result.command_accepted       = accepted;
    result.curtain_position_out   = curtain_position_next;
    result.stretcher_position_out = stretcher_position_next;
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      curtain_position   <= '0;
      stretcher_position <= '0;
      pending_target     <= '0;
      active_motor       <= MOTOR_STRETCHER;
      move_forward       <= 1'b0;
      phase_index        <= 2'd0;
      steps_left         <= '0;
      moving             <= 1'b0;
    end else if (in_acc) begin
      curtain_position   <= curtain_position_next;
      stretcher_position <= stretcher_position_next;
      pending_target     <= pending_target_next;
      active_motor       <= active_motor_next;
      move_forward       <= move_forward_next;
      phase_index        <= phase_index_next;
      steps_left         <= steps_left_next;
      moving             <= moving_next;
    end
  end

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && m_tready) begin
      if (skid_valid) begin
        out_word   <= skid_word;
        skid_valid <= 1'b0;
      end else if (in_acc) begin
        out_word <= result;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (in_acc) begin
        out_word  <= result;
        out_valid <= 1'b1;
      end
    end else if (in_acc) begin
      skid_word  <= result;
      skid_valid <= 1'b1;
    end
  end

  // A word in the skid entry always has one ahead of it.
  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  // A running move always has full steps left to run.
  assert property (@(posedge clk) disable iff (rst) moving |-> (steps_left != '0))
    else $error("move in progress with no steps left");

  // Idle means the phase sits at the start of a step.
  assert property (@(posedge clk) disable iff (rst) !moving |-> (phase_index == 2'd0))
    else $error("phase not reset while idle");

  // A started command drives no coils in its own result word.
  assert property (@(posedge clk) disable iff (rst)
                   (in_acc && result.command_accepted) |-> (result.coil_pattern == 8'h00))
    else $error("command word drove a coil pattern");

endmodule
